// ----- sv/lmus_pkg.sv -----
// lmus_pkg: shared types and constants for the logistic-map sequence core.
// No dependencies; imported by the top level and lmus_mul.
`timescale 1ns / 1ps

package lmus_pkg;

   // point and result fields
   localparam int unsigned POINT_W      = 16;
   localparam int unsigned COUNT_W      = 16;

   // visited map, packed into rows of a RAM
   localparam int unsigned MAP_ENTRIES  = 65536;
   localparam int unsigned ROW_WIDTH    = 64;
   localparam int unsigned ROW_COUNT    = MAP_ENTRIES / ROW_WIDTH;
   localparam int unsigned ROW_ADDR_W   = $clog2(ROW_COUNT);
   localparam int unsigned BIT_SEL_W    = $clog2(ROW_WIDTH);

   // shared multiplier
   localparam int unsigned MUL_A_W      = 32;
   localparam int unsigned MUL_B_W      = 16;
   localparam int unsigned MUL_P_W      = MUL_A_W + MUL_B_W;
   localparam int unsigned RESULT_SHIFT = 30;

   // map constants
   localparam logic [POINT_W-1:0] ZERO_POINT_SUB  = 16'h1337;
   localparam logic [POINT_W-1:0] ZERO_RESULT_SUB = 16'hC0DE;
   localparam logic [POINT_W-1:0] DEFAULT_SEED    = 16'h4B1D;
   localparam logic [MUL_B_W-1:0] MAP_GAIN        = 16'd65533;
   localparam logic [2:0]         REPEAT_LIMIT    = 3'd5;

   // configuration
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [COUNT_W-1:0] WARMUP_RESET = 16'd64;
   localparam logic [COUNT_W-1:0] LENGTH_RESET = 16'd32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEED   = 2'd0,
      CSR_WARMUP = 2'd1,
      CSR_LENGTH = 2'd2
   } csr_index_type;

   localparam logic CMD_RESTART = 1'b0;
   localparam logic CMD_STEP    = 1'b1;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

// ----- sv/logistic_map_unique_sequence_core.sv -----
// logistic_map_unique_sequence_core: top level, sequencer and visited map.
// Depends on lmus_pkg, lmus_mul and lmus_ram.
`timescale 1ns / 1ps

// Emits distinct 16-bit values of a fixed-point logistic map
// x' = (x * (65536 - x) * 65533) >> 30 (low 16 bits; x = 0 is taken as 0x1337,
// a zero result becomes 0xC0DE). A request with command 1 runs one map step
// and, if the value has not been seen since the last restart, returns it with
// its index and a last flag; repeats return nothing, and after six repeats in
// a row the point is XORed with the request's entropy. Once sequence_length
// values are out, steps return nothing. A request with command 0 loads the
// seed (0x4B1D when zero), clears the visited map and runs warmup_steps
// discarded steps. Both products go through one registered multiplier, so a
// map step is two multiplier passes plus a result state; after a step request
// is accepted, req_ready stays low through ST_MUL_A, ST_MUL_B (multiply,
// multiply), ST_RESULT (visited-map read) and ST_CHECK (check and write), so a
// new request is taken only once the previous step is through. A step after the
// sequence is complete is absorbed in the accept cycle. The visited map is a
// 1024 x 64-bit RAM; clearing it sweeps one row a cycle, and after reset the
// block holds req_ready low for the same sweep. A result waits in an output
// register, so the next request is taken while it is still pending; a new
// value is held back only if the previous one has not yet been taken.
// Register writes (csr_wr_en) are taken in any cycle: seed applies at the next
// restart, warmup at the next restart or one in progress, the length at once.

module logistic_map_unique_sequence_core
   import lmus_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  logic [POINT_W-1:0]     req_entropy,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [POINT_W-1:0]     rsp_value,
   output logic [COUNT_W-1:0]     rsp_index,
   output logic                   rsp_last,
   // configuration writes
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_RESULT,
      ST_CHECK
   } state_type;

   // registers
   state_type             state_ff,     state_in;
   logic [POINT_W-1:0]    point_ff,     point_in;
   logic [2:0]            repeat_ff,    repeat_in;
   logic [COUNT_W-1:0]    emitted_ff,   emitted_in;
   logic                  warm_ff,      warm_in;
   logic [COUNT_W-1:0]    warm_cnt_ff,  warm_cnt_in;
   logic [ROW_ADDR_W-1:0] clr_cnt_ff,   clr_cnt_in;
   logic [POINT_W-1:0]    ent_ff,       ent_in;
   logic [CSR_DATA_W-1:0] seed_ff,      seed_in;
   logic [COUNT_W-1:0]    warmup_ff,    warmup_in;
   logic [COUNT_W-1:0]    length_ff,    length_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POINT_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                  rsp_last_ff,  rsp_last_in;

   // datapath
   mul_req_type           mul_req;
   logic [MUL_P_W-1:0]    mul_p;
   logic [POINT_W-1:0]    x_sel;
   logic [POINT_W-1:0]    map_raw;
   logic [POINT_W-1:0]    map_val;
   logic [2:0]            repeat_inc;
   logic [COUNT_W:0]      emitted_inc;
   logic [COUNT_W-1:0]    warm_cnt_inc;

   // visited map
   logic                  ram_wr_en;
   logic [ROW_ADDR_W-1:0] ram_wr_addr;
   logic [ROW_WIDTH-1:0]  ram_wr_data;
   logic [ROW_ADDR_W-1:0] ram_rd_addr;
   logic [ROW_WIDTH-1:0]  ram_rd_data;
   logic [BIT_SEL_W-1:0]  bit_sel;
   logic                  seen;
   logic                  emit_ok;
   logic                  emit_now;

   // ---------------------------------------------------------------- map step
   // point 0 stands for 0x1337; first pass x*(65536-x), second pass *65533
   assign x_sel = (point_ff == '0) ? ZERO_POINT_SUB : point_ff;

   always_comb begin
      mul_req.en = (state_ff == ST_MUL_A) || (state_ff == ST_MUL_B);
      if (state_ff == ST_MUL_A) begin
         mul_req.a = MUL_A_W'(x_sel);
         mul_req.b = MUL_B_W'((POINT_W+1)'(1) << POINT_W) - MUL_B_W'(x_sel);
      end else begin
         mul_req.a = mul_p[MUL_A_W-1:0];
         mul_req.b = MAP_GAIN;
      end
   end

   lmus_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (mul_p)
   );

   assign map_raw = mul_p[RESULT_SHIFT +: POINT_W];
   assign map_val = (map_raw == '0) ? ZERO_RESULT_SUB : map_raw;

   // ------------------------------------------------------------- visited map
   // row = value[15:6], bit = value[5:0]; the read is issued in the result
   // cycle and its data checked the cycle after, where point_ff holds the value
   assign ram_rd_addr = (state_ff == ST_RESULT) ? map_val[POINT_W-1 -: ROW_ADDR_W]
                                                : point_ff[POINT_W-1 -: ROW_ADDR_W];
   assign bit_sel  = point_ff[BIT_SEL_W-1:0];
   assign seen     = ram_rd_data[bit_sel];
   assign emit_ok  = !rsp_valid_ff || rsp_ready;
   assign emit_now = (state_ff == ST_CHECK) && !seen && emit_ok;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = point_ff[POINT_W-1 -: ROW_ADDR_W];
      ram_wr_data = ram_rd_data | (ROW_WIDTH'(1) << bit_sel);
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else if (emit_now) begin
         ram_wr_en   = 1'b1;
      end
   end

   lmus_ram #(
      .WIDTH (ROW_WIDTH),
      .DEPTH (ROW_COUNT)
   ) u_visited (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // --------------------------------------------------------------- sequencer
   assign req_ready    = (state_ff == ST_IDLE);
   assign repeat_inc   = repeat_ff + 3'd1;
   assign emitted_inc  = {1'b0, emitted_ff} + (COUNT_W+1)'(1);
   assign warm_cnt_inc = warm_cnt_ff + COUNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      point_in     = point_ff;
      repeat_in    = repeat_ff;
      emitted_in   = emitted_ff;
      warm_in      = warm_ff;
      warm_cnt_in  = warm_cnt_ff;
      clr_cnt_in   = clr_cnt_ff;
      ent_in       = ent_ff;
      seed_in      = seed_ff;
      warmup_in    = warmup_ff;
      length_in    = length_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SEED:   seed_in   = csr_wdata;
            CSR_WARMUP: warmup_in = csr_wdata[COUNT_W-1:0];
            CSR_LENGTH: length_in = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ROW_ADDR_W'(1);
            if (clr_cnt_ff == ROW_ADDR_W'(ROW_COUNT - 1)) begin
               if (warm_ff && (warmup_ff != '0)) begin
                  state_in = ST_MUL_A;
               end else begin
                  warm_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ent_in = req_entropy;
               if (req_command == CMD_RESTART) begin
                  point_in    = (seed_ff != '0) ? seed_ff[POINT_W-1:0] : DEFAULT_SEED;
                  repeat_in   = '0;
                  emitted_in  = '0;
                  warm_in     = 1'b1;
                  warm_cnt_in = '0;
                  clr_cnt_in  = '0;
                  state_in    = ST_CLEAR;
               end else if (emitted_ff < length_ff) begin
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_RESULT;
         ST_RESULT: begin
            point_in = map_val;
            if (warm_ff) begin
               warm_cnt_in = warm_cnt_inc;
               if (warm_cnt_inc == warmup_ff) begin
                  warm_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MUL_A;
               end
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (seen) begin
               // stuck on a visited value: kick the point after six in a row
               if (repeat_inc > REPEAT_LIMIT) begin
                  point_in  = point_ff ^ ent_ff;
                  repeat_in = '0;
               end else begin
                  repeat_in = repeat_inc;
               end
               state_in = ST_IDLE;
            end else if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = point_ff;
               rsp_index_in = emitted_ff;
               rsp_last_in  = (emitted_inc == {1'b0, length_ff});
               emitted_in   = emitted_inc[COUNT_W-1:0];
               repeat_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         point_ff     <= '0;
         repeat_ff    <= '0;
         emitted_ff   <= '0;
         warm_ff      <= 1'b0;
         warm_cnt_ff  <= '0;
         clr_cnt_ff   <= '0;
         ent_ff       <= '0;
         seed_ff      <= '0;
         warmup_ff    <= WARMUP_RESET;
         length_ff    <= LENGTH_RESET;
         rsp_valid_ff <= 1'b0;
         rsp_value_ff <= '0;
         rsp_index_ff <= '0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         point_ff     <= point_in;
         repeat_ff    <= repeat_in;
         emitted_ff   <= emitted_in;
         warm_ff      <= warm_in;
         warm_cnt_ff  <= warm_cnt_in;
         clr_cnt_ff   <= clr_cnt_in;
         ent_ff       <= ent_in;
         seed_ff      <= seed_in;
         warmup_ff    <= warmup_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_value_ff <= rsp_value_in;
         rsp_index_ff <= rsp_index_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_last  = rsp_last_ff;

   // -------------------------------------------------------------- assertions
   // map output is never zero, so an emitted value never is either
   a_value_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff != '0))
      else $error("response value is zero");

   // repeat counter is cleared before it can pass the limit
   a_repeat_bound: assert property (@(posedge clock) disable iff (reset)
      repeat_ff <= REPEAT_LIMIT)
      else $error("repeat counter beyond limit");

   // each emitted value advances the count by exactly one
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      emit_now |=> (emitted_ff == $past(emitted_ff) + COUNT_W'(1)))
      else $error("emitted count not advanced by one");

   // visited-map write outside the clear sweep only for a fresh value
   a_write_fresh: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && (state_ff != ST_CLEAR)) |-> (emit_now && rsp_valid_in))
      else $error("visited map written without a response");

endmodule

// ----- sv/lmus_ram.sv -----
// lmus_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lmus_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/lmus_mul.sv -----
// lmus_mul: shared registered 32x16 multiplier used for both map products.
// Depends on lmus_pkg.
`timescale 1ns / 1ps

module lmus_mul
   import lmus_pkg::*;
(
   input  logic               clock,
   input  mul_req_type        mul_req,
   output logic [MUL_P_W-1:0] product
);

   logic [MUL_P_W-1:0] product_ff;
   logic [MUL_P_W-1:0] product_in;

   assign product_in = MUL_P_W'(mul_req.a) * MUL_P_W'(mul_req.b);

   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule
